// ===== hw/rtl/sfb_pkg.sv =====
// shared types and constants of the stuffed frame builder
// no dependencies; imported by every module of the block
package sfb_pkg;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W   = 4;
    localparam logic [CFG_INDEX_W-1:0] REG_START_MARKER = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_END_MARKER   = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ESCAPE_BYTE  = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CHK_MODULUS  = 4'd3;
    localparam int unsigned CFG_DATA_W    = 9;

    // reset values of the registers
    localparam logic [7:0] RST_START_MARKER = 8'd2;
    localparam logic [7:0] RST_END_MARKER   = 8'd3;
    localparam logic [7:0] RST_ESCAPE_BYTE  = 8'd16;
    localparam logic [8:0] MAX_MODULUS      = 9'd256;

    // default depth of the command queue between front and back
    localparam int unsigned CMD_QUEUE_DEPTH = 2;

    // output byte slots of one command, in stream order
    localparam int unsigned NUM_SLOTS  = 7;
    localparam int unsigned SLOT_START = 0;
    localparam int unsigned SLOT_SEQ   = 1;
    localparam int unsigned SLOT_DESC  = 2;
    localparam int unsigned SLOT_DATA  = 3;
    localparam int unsigned SLOT_CESC  = 4;
    localparam int unsigned SLOT_CHK   = 5;
    localparam int unsigned SLOT_END   = 6;

    // live configuration
    typedef struct packed {
        logic [7:0] start_marker;
        logic [7:0] end_marker;
        logic [7:0] escape_byte;
        logic [8:0] modulus;      // effective modulus, 1..256
    } cfg_t;

    // one classified word handed from front to back
    typedef struct packed {
        logic       hdr;          // send start marker and sequence byte
        logic [7:0] seq;
        logic       has_data;     // send the stuffed data byte
        logic [7:0] data;
        logic       trl;          // send checksum and end marker
        logic [7:0] chk;
    } cmd_t;

endpackage

// ===== hw/rtl/sfb_front.sv =====
// front end: accepts input words, keeps the running sum and builds commands
// depends on sfb_pkg
module sfb_front
    import sfb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       in_mode,
    input  logic [7:0] in_data,
    input  logic       in_first,
    input  logic       in_last,
    input  logic [7:0] in_seq,
    output logic       push_valid,
    input  logic       push_ready,
    output cmd_t       push_cmd
);

    // remainder unit: three bits of the dividend per cycle
    localparam int unsigned DIV_BITS     = 9;
    localparam int unsigned BITS_PER_CYC = 3;
    localparam int unsigned DIV_CYCLES   = DIV_BITS / BITS_PER_CYC;
    localparam int unsigned CNT_W        = $clog2(DIV_CYCLES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_CYCLES - 1);

    typedef enum logic [2:0] {
        FR_IDLE = 3'b001,
        FR_CALC = 3'b010,
        FR_PUSH = 3'b100
    } fr_state_t;

    fr_state_t           state_reg, state_next;
    logic [7:0]          sum_reg, sum_next;
    logic [DIV_BITS-1:0] dividend_reg, dividend_next;
    logic [7:0]          rem_reg, rem_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    cmd_t                cmd_reg, cmd_next;
    logic [7:0]          rem_step;

    // one restoring step: shift in a bit, subtract the modulus if it fits
    function automatic logic [7:0] mod_step(input logic [7:0] r, input logic b,
                                            input logic [8:0] m);
        logic [8:0] r9;
        r9 = {r, b};
        if (r9 >= m) begin
            mod_step = 8'(r9 - m);
        end else begin
            mod_step = r9[7:0];
        end
    endfunction

    // three chained steps on the top bits of the dividend
    always_comb begin
        rem_step = rem_reg;
        for (int i = 0; i < BITS_PER_CYC; i++) begin
            rem_step = mod_step(rem_step, dividend_reg[DIV_BITS-1-i], cfg.modulus);
        end
    end

    assign in_ready   = (state_reg == FR_IDLE);
    assign push_valid = (state_reg == FR_PUSH);
    assign push_cmd   = cmd_reg;

    // control
    always_comb begin
        state_next    = state_reg;
        sum_next      = sum_reg;
        dividend_next = dividend_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        cmd_next      = cmd_reg;
        unique case (state_reg)
            FR_IDLE: begin
                if (in_valid) begin
                    cmd_next.hdr      = in_mode | in_first;
                    cmd_next.seq      = in_seq;
                    cmd_next.has_data = ~in_mode;
                    cmd_next.data     = in_data;
                    cmd_next.trl      = in_mode | in_last;
                    cmd_next.chk      = 8'd0;
                    if (in_mode) begin
                        sum_next   = 8'd0;
                        state_next = FR_PUSH;
                    end else begin
                        dividend_next = (in_first ? 9'd0 : {1'b0, sum_reg})
                                        + {1'b0, in_data};
                        rem_next      = 8'd0;
                        cnt_next      = '0;
                        state_next    = FR_CALC;
                    end
                end
            end
            FR_CALC: begin
                rem_next      = rem_step;
                dividend_next = dividend_reg << BITS_PER_CYC;
                cnt_next      = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST) begin
                    cmd_next.chk = rem_step;
                    sum_next     = cmd_reg.trl ? 8'd0 : rem_step;
                    state_next   = FR_PUSH;
                end
            end
            FR_PUSH: begin
                if (push_ready) begin
                    state_next = FR_IDLE;
                end
            end
            default: state_next = FR_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FR_IDLE;
            sum_reg   <= 8'd0;
        end else begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
        end
        dividend_reg <= dividend_next;
        rem_reg      <= rem_next;
        cnt_reg      <= cnt_next;
        cmd_reg      <= cmd_next;
    end

    // partial remainder stays below the modulus throughout the division
    a_rem_below_mod: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == FR_CALC) |-> ({1'b0, rem_reg} < cfg.modulus))
        else $error("partial remainder not below modulus");

endmodule

// ===== hw/rtl/sfb_cmd_queue.sv =====
// short register queue of commands between front and back
// depends on sfb_pkg
module sfb_cmd_queue
    import sfb_pkg::*;
#(
    parameter int unsigned DEPTH = CMD_QUEUE_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop,
    output cmd_t pop_cmd
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop & pop_valid;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // fill count never passes the depth
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("command queue overflow");

endmodule

// ===== hw/rtl/sfb_back.sv =====
// back end: expands each command into framed bytes on a registered output
// depends on sfb_pkg
module sfb_back
    import sfb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       cmd_valid,
    input  cmd_t       cmd,
    output logic       cmd_pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_frame_end,
    output logic       out_last
);

    logic                 active_reg, active_next;
    logic [NUM_SLOTS-1:0] remain_reg, remain_next;
    logic                 valid_reg, valid_next;
    logic [7:0]           byte_reg, byte_next;
    logic                 frame_end_reg, frame_end_next;
    logic                 last_reg, last_next;
    logic [NUM_SLOTS-1:0] slot_mask;
    logic [NUM_SLOTS-1:0] pick;
    logic [NUM_SLOTS-1:0] left;
    logic [7:0]           slot_byte [NUM_SLOTS];
    logic [7:0]           pick_byte;
    logic                 slot_free;

    function automatic logic is_special(input logic [7:0] b, input cfg_t c);
        is_special = (b == c.start_marker) || (b == c.end_marker) ||
                     (b == c.escape_byte);
    endfunction

    // which bytes this command sends
    always_comb begin
        slot_mask             = '0;
        slot_mask[SLOT_START] = cmd.hdr;
        slot_mask[SLOT_SEQ]   = cmd.hdr;
        slot_mask[SLOT_DESC]  = cmd.has_data & is_special(cmd.data, cfg);
        slot_mask[SLOT_DATA]  = cmd.has_data;
        slot_mask[SLOT_CESC]  = cmd.trl & is_special(cmd.chk, cfg);
        slot_mask[SLOT_CHK]   = cmd.trl;
        slot_mask[SLOT_END]   = cmd.trl;
    end

    // byte value of every slot
    always_comb begin
        slot_byte[SLOT_START] = cfg.start_marker;
        slot_byte[SLOT_SEQ]   = cmd.seq;
        slot_byte[SLOT_DESC]  = cfg.escape_byte;
        slot_byte[SLOT_DATA]  = cmd.data;
        slot_byte[SLOT_CESC]  = cfg.escape_byte;
        slot_byte[SLOT_CHK]   = cmd.chk;
        slot_byte[SLOT_END]   = cfg.end_marker;
    end

    // earliest outstanding slot
    assign pick = remain_reg & (~remain_reg + NUM_SLOTS'(1));
    assign left = remain_reg & ~pick;

    always_comb begin
        pick_byte = 8'd0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (pick[i]) begin
                pick_byte = pick_byte | slot_byte[i];
            end
        end
    end

    assign slot_free = ~valid_reg | out_ready;

    // sequencing of output words
    always_comb begin
        active_next    = active_reg;
        remain_next    = remain_reg;
        valid_next     = valid_reg & ~out_ready;
        byte_next      = byte_reg;
        frame_end_next = frame_end_reg;
        last_next      = last_reg;
        cmd_pop        = 1'b0;
        if (!active_reg) begin
            if (cmd_valid) begin
                active_next = 1'b1;
                remain_next = slot_mask;
            end
        end else if (slot_free) begin
            valid_next     = 1'b1;
            byte_next      = pick_byte;
            frame_end_next = pick[SLOT_END];
            last_next      = (left == '0);
            remain_next    = left;
            if (left == '0) begin
                cmd_pop     = 1'b1;
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            remain_reg <= '0;
            valid_reg  <= 1'b0;
        end else begin
            active_reg <= active_next;
            remain_reg <= remain_next;
            valid_reg  <= valid_next;
        end
        byte_reg      <= byte_next;
        frame_end_reg <= frame_end_next;
        last_reg      <= last_next;
    end

    assign out_valid     = valid_reg;
    assign out_byte      = byte_reg;
    assign out_frame_end = frame_end_reg;
    assign out_last      = last_reg;

    // a loaded command always has bytes left and stays at the queue head
    a_active_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (remain_reg != '0) && cmd_valid)
        else $error("active command with nothing left to send");

    // the end marker word always closes its command
    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && frame_end_reg) |-> last_reg)
        else $error("end marker not on last word of command");

endmodule

// ===== hw/rtl/stuffed_frame_builder.sv =====
// top level of the stuffed frame builder: ports, configuration registers
// depends on sfb_pkg, sfb_front, sfb_cmd_queue, sfb_back
// Byte-stuffing framer with an additive checksum. Each input word carries one
// data byte (or, in mode 1, an empty block) and yields 1 to 7 output words:
// start marker and sequence byte when a block opens, the data byte with an
// escape in front when it matches a marker or the escape value, and the
// checksum (escaped likewise) plus end marker when the block closes; tlast on
// the output marks the final word of each input word. The front takes a word,
// runs a data word through the bit-serial remainder unit for the checksum
// modulus and then pushes its command into the queue; an empty block goes
// straight to the push. The back loads a command and then sends one output
// byte per cycle unless the output stalls, so the slower side sets the rate.
// A short command queue lets the front run ahead while the back drains.
// Configuration writes are always accepted and must only be issued while idle.
module stuffed_frame_builder
    import sfb_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = CMD_QUEUE_DEPTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // input words
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [15:0]            s_tdata,   // data_byte[7:0], sequence_number[15:8]
    input  logic [1:0]             s_tuser,   // mode[0], first_of_block[1]
    input  logic                   s_tlast,   // last_of_block
    // framed output words
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,   // out_byte[7:0]
    output logic                   m_tuser,   // frame_end[0]
    output logic                   m_tlast    // run_last
);

    cfg_t cfg_reg, cfg_next;
    logic push_valid, push_ready;
    cmd_t push_cmd;
    logic pop_valid, pop;
    cmd_t pop_cmd;

    assign cfg_ready = 1'b1;

    // register writes; an out of range modulus acts as the maximum
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_START_MARKER: cfg_next.start_marker = cfg_data[7:0];
                REG_END_MARKER:   cfg_next.end_marker   = cfg_data[7:0];
                REG_ESCAPE_BYTE:  cfg_next.escape_byte  = cfg_data[7:0];
                REG_CHK_MODULUS: begin
                    if (cfg_data == '0 || cfg_data > MAX_MODULUS) begin
                        cfg_next.modulus = MAX_MODULUS;
                    end else begin
                        cfg_next.modulus = cfg_data;
                    end
                end
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_marker <= RST_START_MARKER;
            cfg_reg.end_marker   <= RST_END_MARKER;
            cfg_reg.escape_byte  <= RST_ESCAPE_BYTE;
            cfg_reg.modulus      <= MAX_MODULUS;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    sfb_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_mode    (s_tuser[0]),
        .in_data    (s_tdata[7:0]),
        .in_first   (s_tuser[1]),
        .in_last    (s_tlast),
        .in_seq     (s_tdata[15:8]),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    sfb_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_cmd    (pop_cmd)
    );

    sfb_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .cmd_valid     (pop_valid),
        .cmd           (pop_cmd),
        .cmd_pop       (pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_byte      (m_tdata),
        .out_frame_end (m_tuser),
        .out_last      (m_tlast)
    );

endmodule

// ===== tb/stuffed_frame_builder_test.sv =====
// testbench of the stuffed frame builder: stream driver, output monitor, framing predictor
// depends on sfb_pkg and stuffed_frame_builder from hw/rtl
// directed frames first, then random blocks under several marker and modulus settings
module stuffed_frame_builder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sfb_pkg::*;

    localparam logic MODE_DATA  = 1'b0;
    localparam logic MODE_EMPTY = 1'b1;
    // register indexes with no register behind them
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LOW  = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HIGH = 4'd15;
    localparam int SETTLE_CYCLES = 24;
    localparam int MAX_REPORTS   = 10;
    localparam int GAP_PERCENT   = 16;

    typedef struct packed {
        logic       mode;
        logic [7:0] data;
        logic       first;
        logic       last;
        logic [7:0] seq;
    } in_word_t;

    typedef struct packed {
        logic [7:0] value;
        logic       frame_end;
        logic       run_last;
    } out_word_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [15:0]            s_tdata   = '0;   // data_byte[7:0], sequence_number[15:8]
    logic [1:0]             s_tuser   = '0;   // mode[0], first_of_block[1]
    logic                   s_tlast   = 1'b0; // last_of_block
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [7:0]             m_tdata;          // out_byte[7:0]
    logic                   m_tuser;          // frame_end[0]
    logic                   m_tlast;          // run_last

    // framer's view of the registers and the checksum state
    logic [7:0] mark_start  = RST_START_MARKER;
    logic [7:0] mark_end    = RST_END_MARKER;
    logic [7:0] mark_esc    = RST_ESCAPE_BYTE;
    logic [8:0] sum_modulus = MAX_MODULUS;
    logic [7:0] block_sum   = 8'd0;

    in_word_t  pending[$];
    out_word_t framed[$];
    bit        word_taken = 1'b0;
    bit        cfg_taken  = 1'b0;
    bit        no_gaps    = 1'b0;
    int        mismatches = 0;

    stuffed_frame_builder DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #2 aclk = ~aclk;

    // framing predictor
    function automatic bit is_marker(logic [7:0] b);
        return b == mark_start || b == mark_end || b == mark_esc;
    endfunction

    task automatic push_byte(logic [7:0] b, logic fe);
        framed.push_back('{value: b, frame_end: fe, run_last: 1'b0});
    endtask

    task automatic push_stuffed(logic [7:0] b);
        if (is_marker(b)) begin
            push_byte(mark_esc, 1'b0);
        end
        push_byte(b, 1'b0);
    endtask

    task automatic push_trailer();
        push_stuffed(block_sum);
        push_byte(mark_end, 1'b1);
        block_sum = 8'd0;
    endtask

    task automatic frame_word(in_word_t w);
        int modv;
        int total;
        // a modulus of zero or above the byte range counts as 256
        modv = (sum_modulus == 9'd0 || sum_modulus > MAX_MODULUS) ? 256 : int'(sum_modulus);
        if (w.mode == MODE_EMPTY) begin
            block_sum = 8'd0;
            push_byte(mark_start, 1'b0);
            push_byte(w.seq, 1'b0);
            push_trailer();
        end else begin
            if (w.first) begin
                block_sum = 8'd0;
                push_byte(mark_start, 1'b0);
                push_byte(w.seq, 1'b0);
            end
            push_stuffed(w.data);
            total = (int'(block_sum) + int'(w.data)) % modv;
            block_sum = total[7:0];
            if (w.last) begin
                push_trailer();
            end
        end
        framed[framed.size() - 1].run_last = 1'b1;
    endtask

    task automatic apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_START_MARKER: mark_start = val[7:0];
            REG_END_MARKER:   mark_end = val[7:0];
            REG_ESCAPE_BYTE:  mark_esc = val[7:0];
            REG_CHK_MODULUS:  sum_modulus = val;
            default: ;
        endcase
    endtask

    task automatic note_mismatch(string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("mismatch: %s", what);
        end
    endtask

    task automatic check_word();
        out_word_t want;
        if (framed.size() == 0) begin
            note_mismatch($sformatf("word %02h end %0b last %0b with nothing expected",
                                    m_tdata, m_tuser, m_tlast));
        end else begin
            want = framed.pop_front();
            if (m_tdata !== want.value || m_tuser !== want.frame_end
                    || m_tlast !== want.run_last) begin
                note_mismatch($sformatf(
                    "expected byte %02h end %0b last %0b, got byte %02h end %0b last %0b",
                    want.value, want.frame_end, want.run_last, m_tdata, m_tuser, m_tlast));
            end
        end
    endtask

    // sampling at the rising edge: register writes, accepted words, output words
    always @(posedge aclk) begin
        word_taken <= aresetn && s_tvalid && s_tready;
        cfg_taken  <= aresetn && cfg_valid && cfg_ready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                apply_reg(cfg_index, cfg_data);
            end
            if (s_tvalid && s_tready) begin
                frame_word(pending[0]);
                void'(pending.pop_front());
            end
            if (m_tvalid && m_tready) begin
                check_word();
            end
        end
    end

    // driving at the falling edge: input words and output back-pressure
    always @(negedge aclk) begin
        m_tready <= aresetn && (no_gaps || $urandom_range(99) >= GAP_PERCENT);
        if (!s_tvalid || word_taken) begin
            if (aresetn && pending.size() > 0
                    && (no_gaps || $urandom_range(99) >= GAP_PERCENT)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {pending[0].seq, pending[0].data};
                s_tuser  <= {pending[0].first, pending[0].mode};
                s_tlast  <= pending[0].last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // stimulus helpers, entered at a falling edge
    task automatic add_word(logic mode, logic [7:0] data, logic first, logic last,
                            logic [7:0] seq);
        pending.push_back('{mode: mode, data: data, first: first, last: last, seq: seq});
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(negedge aclk); while (!cfg_taken);
    endtask

    task automatic drain();
        do @(negedge aclk); while (pending.size() != 0 || framed.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // bytes lean towards the current marker values
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(99);
        if (r < 10) begin
            return mark_start;
        end else if (r < 20) begin
            return mark_end;
        end else if (r < 30) begin
            return mark_esc;
        end
        return 8'($urandom_range(255));
    endfunction

    task automatic add_blocks(int count);
        int made;
        int len;
        int kind;
        made = 0;
        while (made < count) begin
            kind = $urandom_range(99);
            if (kind < 70) begin
                // well-formed block
                len = ($urandom_range(9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 5);
                for (int i = 0; i < len; i++) begin
                    add_word(MODE_DATA, pick_byte(), i == 0, i == len - 1, pick_byte());
                end
                made += len;
            end else if (kind < 82) begin
                // empty block with junk in the unused fields
                add_word(MODE_EMPTY, 8'($urandom_range(255)), 1'($urandom_range(1)),
                         1'($urandom_range(1)), pick_byte());
                made++;
            end else if (kind < 92) begin
                // stray byte outside any opened block
                add_word(MODE_DATA, pick_byte(), 1'b0, 1'($urandom_range(1)),
                         8'($urandom_range(255)));
                made++;
            end else begin
                // block opened and never closed
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++) begin
                    add_word(MODE_DATA, pick_byte(), i == 0, 1'b0, 8'($urandom_range(255)));
                end
                made += len;
            end
        end
    endtask

    task automatic random_phase(logic [7:0] st, logic [7:0] en, logic [7:0] es,
                                logic [8:0] md, int count);
        write_reg(REG_START_MARKER, {1'b0, st});
        write_reg(REG_END_MARKER, {1'b0, en});
        write_reg(REG_ESCAPE_BYTE, {1'b0, es});
        write_reg(REG_CHK_MODULUS, md);
        cfg_valid <= 1'b0;
        add_blocks(count / 2);
        // sender holds off until the framer has emptied
        drain();
        add_blocks(count - count / 2);
        drain();
    endtask

    initial begin
        logic [7:0] same;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // reset markers: stuffing of each marker, unstuffed sequence, escaped checksum
        add_word(MODE_EMPTY, 8'h00, 1'b0, 1'b0, 8'h00);
        add_word(MODE_DATA, 8'h02, 1'b1, 1'b0, 8'h02);
        add_word(MODE_DATA, 8'h03, 1'b0, 1'b0, 8'hFF);
        add_word(MODE_DATA, 8'h10, 1'b0, 1'b0, 8'h00);
        add_word(MODE_DATA, 8'h00, 1'b0, 1'b0, 8'h00);
        add_word(MODE_DATA, 8'hFF, 1'b0, 1'b1, 8'h00);
        add_word(MODE_DATA, 8'h10, 1'b1, 1'b1, 8'h10);
        // data with no block opened, checksum lands on the end marker
        add_word(MODE_DATA, 8'h05, 1'b0, 1'b0, 8'hAA);
        add_word(MODE_DATA, 8'hFE, 1'b0, 1'b1, 8'h00);
        add_word(MODE_EMPTY, 8'hFF, 1'b1, 1'b1, 8'hFF);
        // a block reopened before it was closed
        add_word(MODE_DATA, 8'h80, 1'b1, 1'b0, 8'h03);
        add_word(MODE_DATA, 8'h7F, 1'b1, 1'b1, 8'h55);
        drain();

        // all markers zero, modulus one: checksum always zero and always escaped
        write_reg(REG_START_MARKER, 9'd0);
        write_reg(REG_END_MARKER, 9'd0);
        write_reg(REG_ESCAPE_BYTE, 9'd0);
        write_reg(REG_CHK_MODULUS, 9'd1);
        cfg_valid <= 1'b0;
        add_word(MODE_EMPTY, 8'h00, 1'b0, 1'b0, 8'h00);
        add_word(MODE_DATA, 8'h00, 1'b1, 1'b0, 8'h00);
        add_word(MODE_DATA, 8'hFF, 1'b0, 1'b1, 8'hFF);
        add_word(MODE_DATA, 8'h00, 1'b1, 1'b1, 8'h00);
        drain();

        // writes to spare indexes change nothing; modulus zero counts as 256
        write_reg(REG_SPARE_HIGH, 9'h1FF);
        write_reg(REG_SPARE_LOW, 9'h0AA);
        write_reg(REG_START_MARKER, 9'h0FF);
        write_reg(REG_END_MARKER, 9'h0FE);
        write_reg(REG_ESCAPE_BYTE, 9'h0FF);
        write_reg(REG_CHK_MODULUS, 9'd0);
        cfg_valid <= 1'b0;
        add_word(MODE_DATA, 8'hFF, 1'b1, 1'b0, 8'hFF);
        add_word(MODE_DATA, 8'hFE, 1'b0, 1'b0, 8'h00);
        add_word(MODE_DATA, 8'h01, 1'b0, 1'b1, 8'h00);
        add_word(MODE_EMPTY, 8'h5A, 1'b0, 1'b1, 8'hFE);
        drain();

        // random blocks under several settings
        random_phase(8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)), 9'($urandom_range(1, 256)), 100);
        no_gaps = 1'b1;
        random_phase(8'hFF, 8'h00, 8'h80, 9'd2, 100);
        no_gaps = 1'b0;
        same = 8'($urandom_range(255));
        random_phase(same, same, same, 9'd257, 100);
        random_phase(8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)), 9'h1FF, 100);
        random_phase(8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)), 9'($urandom_range(1, 7)), 100);

        if (mismatches == 0 && framed.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
